// ===== rtl/hrlm_pkg.sv =====
// Package for the request line route matcher: types, codes and constants.
// Used by hrlm_ctrl, hrlm_dp and http_request_line_route_matcher.
package hrlm_pkg;

    localparam int MAX_ROUTES_DEF = 16;
    localparam int MAX_URI_DEF    = 64;

    localparam int CFG_W    = 5;
    localparam int STATUS_W = 3;
    localparam int ULEN_W   = 7;
    localparam int HASH_W   = 32;
    localparam int RIDX_W   = 4;
    localparam int IN_DW    = 48;
    localparam int OUT_DW   = 48;

    localparam logic [HASH_W-1:0] FNV_BASIS = 32'd2166136261;
    localparam logic [HASH_W-1:0] FNV_PRIME = 32'd16777619;

    localparam logic [7:0] CH_G     = 8'h47;
    localparam logic [7:0] CH_E     = 8'h45;
    localparam logic [7:0] CH_P     = 8'h50;
    localparam logic [7:0] CH_O     = 8'h4F;
    localparam logic [7:0] CH_SLASH = 8'h2F;
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_CR    = 8'h0D;
    localparam logic [7:0] CH_LF    = 8'h0A;
    localparam logic [7:0] CH_NUL   = 8'h00;

    typedef enum logic [2:0] {
        PH_IDLE,
        PH_SECOND,
        PH_SEEK,
        PH_URI,
        PH_SEARCH,
        PH_DONE
    } t_phase;

    typedef enum logic [STATUS_W-1:0] {
        ST_FOUND      = 3'd0,
        ST_BAD_METHOD = 3'd1,
        ST_NO_URI     = 3'd2,
        ST_TOO_LONG   = 3'd3,
        ST_NOT_FOUND  = 3'd4,
        ST_POST       = 3'd5
    } t_status;

    // controller -> datapath
    typedef struct packed {
        logic    tbl_wr;
        logic    ld_first;
        logic    hash_en;
        logic    clear;
        logic    search_start;
        logic    search_step;
        logic    emit;
        t_status status;
    } t_cmd;

    // datapath -> controller
    typedef struct packed {
        logic b_nul;
        logic b_crlf;
        logic b_slash;
        logic b_space;
        logic method_ok;
        logic too_long;
        logic is_post;
        logic hit;
        logic exhausted;
        logic out_busy;
    } t_sts;

endpackage

// ===== rtl/hrlm_dp.sv =====
// Datapath of the route matcher: byte decode, FNV-1 hash, URI count,
// route table memory with serial search, result register. Uses hrlm_pkg.
module hrlm_dp import hrlm_pkg::*; #(
    parameter int MAX_ROUTES = MAX_ROUTES_DEF,
    parameter int MAX_URI    = MAX_URI_DEF
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  t_cmd              i_cmd,
    output t_sts              o_sts,
    input  logic              i_cfg_wr_en,
    input  logic [CFG_W-1:0]  i_cfg_wr_data,
    input  logic [7:0]        i_byte,
    input  logic [RIDX_W-1:0] i_entry_index,
    input  logic [HASH_W-1:0] i_entry_hash,
    input  logic              i_out_ready,
    output logic              o_out_valid,
    output logic [OUT_DW-1:0] o_out_data
);

    localparam int AW  = (MAX_ROUTES > 1) ? $clog2(MAX_ROUTES) : 1;
    localparam int CW  = $clog2(MAX_ROUTES + 1);
    localparam int NW  = (CW > CFG_W) ? CW : CFG_W;
    localparam int UCW = $clog2(MAX_URI + 1);

    logic [CFG_W-1:0]  r_route_count;
    logic [7:0]        r_first;
    logic [HASH_W-1:0] r_hash;
    logic [UCW-1:0]    r_cnt;
    logic [CW-1:0]     r_idx;
    logic [HASH_W-1:0] r_rd;
    logic [CW-1:0]     r_rd_idx;
    logic              r_rd_vld;
    logic              r_out_vld;
    logic [OUT_DW-1:0] r_out;
    logic [HASH_W-1:0] mem [MAX_ROUTES];

    logic [HASH_W-1:0] n_hash;
    logic [CW-1:0]     n_limit;
    logic              idx_more;
    logic              wr_ok;
    logic              with_uri;
    logic              method_bit;
    logic [31:0]       rd_idx_ext;
    logic [31:0]       cnt_ext;
    logic [OUT_DW-1:0] n_out;

    // entries searched: min(route_count, MAX_ROUTES)
    always_comb begin
        if (NW'(r_route_count) < NW'(MAX_ROUTES)) begin
            n_limit = CW'(NW'(r_route_count));
        end else begin
            n_limit = CW'(MAX_ROUTES);
        end
    end

    assign idx_more = r_idx < n_limit;
    assign wr_ok    = 32'(i_entry_index) < MAX_ROUTES;
    assign n_hash   = (r_hash * FNV_PRIME) ^ HASH_W'(i_byte);

    assign o_sts.b_nul     = i_byte == CH_NUL;
    assign o_sts.b_crlf    = (i_byte == CH_CR) || (i_byte == CH_LF);
    assign o_sts.b_slash   = i_byte == CH_SLASH;
    assign o_sts.b_space   = i_byte == CH_SPACE;
    assign o_sts.method_ok = ((r_first == CH_G) && (i_byte == CH_E)) ||
                             ((r_first == CH_P) && (i_byte == CH_O));
    assign o_sts.too_long  = 32'(r_cnt) >= MAX_URI;
    assign o_sts.is_post   = method_bit;
    assign o_sts.hit       = r_rd_vld && (r_rd == r_hash);
    assign o_sts.exhausted = !r_rd_vld && !idx_more;
    assign o_sts.out_busy  = r_out_vld && !i_out_ready;

    assign method_bit = r_first == CH_P;
    assign with_uri   = (i_cmd.status != ST_BAD_METHOD) && (i_cmd.status != ST_NO_URI);
    assign rd_idx_ext = 32'(r_rd_idx);
    assign cnt_ext    = 32'(r_cnt);

    // fields from bit 0: status, method, path length, path hash, route_index
    always_comb begin
        n_out        = '0;
        n_out[2:0]   = i_cmd.status;
        n_out[3]     = (i_cmd.status != ST_BAD_METHOD) ? method_bit : 1'b0;
        n_out[10:4]  = with_uri ? cnt_ext[ULEN_W-1:0] : '0;
        n_out[42:11] = with_uri ? r_hash : '0;
        n_out[46:43] = (i_cmd.status == ST_FOUND) ? rd_idx_ext[RIDX_W-1:0] : '0;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_route_count <= '0;
            r_first       <= '0;
            r_hash        <= FNV_BASIS;
            r_cnt         <= '0;
            r_out_vld     <= 1'b0;
            r_rd_vld      <= 1'b0;
        end else begin
            if (i_cfg_wr_en) begin
                r_route_count <= i_cfg_wr_data;
            end
            if (i_cmd.clear) begin
                r_first <= '0;
                r_hash  <= FNV_BASIS;
                r_cnt   <= '0;
            end else begin
                if (i_cmd.ld_first) begin
                    r_first <= i_byte;
                end
                if (i_cmd.hash_en) begin
                    r_hash <= n_hash;
                    if (32'(r_cnt) < MAX_URI) begin
                        r_cnt <= r_cnt + 1'b1;
                    end
                end
            end
            if (i_cmd.emit) begin
                r_out_vld <= 1'b1;
            end else if (i_out_ready) begin
                r_out_vld <= 1'b0;
            end
            if (i_cmd.search_start) begin
                r_rd_vld <= 1'b0;
            end else if (i_cmd.search_step) begin
                r_rd_vld <= idx_more;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.emit) begin
            r_out <= n_out;
        end
        if (i_cmd.search_start) begin
            r_idx <= '0;
        end else if (i_cmd.search_step && idx_more) begin
            r_idx    <= r_idx + 1'b1;
            r_rd_idx <= r_idx;
        end
    end

    // route table: one write port, one registered read port
    always_ff @(posedge i_clk) begin
        if (i_cmd.tbl_wr && wr_ok) begin
            mem[AW'(i_entry_index)] <= i_entry_hash;
        end
        if (i_cmd.search_step && idx_more) begin
            r_rd <= mem[r_idx[AW-1:0]];
        end
    end

    assign o_out_valid = r_out_vld;
    assign o_out_data  = r_out;

endmodule

// ===== rtl/hrlm_ctrl.sv =====
// Controller of the route matcher: parse phase state machine and handshake.
// Uses hrlm_pkg; drives the command struct of hrlm_dp.
module hrlm_ctrl import hrlm_pkg::*; (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_valid,
    input  logic i_mode,
    input  logic i_last,
    output logic o_ready,
    input  t_sts i_sts,
    output t_cmd o_cmd
);

    t_phase r_phase;
    t_phase n_phase;
    logic   r_last;
    logic   n_last;
    logic   acc;
    logic   acc_byte;

    // bytes past a result never emit, so they flow even with a full output
    assign o_ready  = (r_phase != PH_SEARCH) && ((r_phase == PH_DONE) || !i_sts.out_busy);
    assign acc      = i_valid && o_ready;
    assign acc_byte = acc && !i_mode;

    // outputs
    always_comb begin
        t_phase mid;
        o_cmd        = '0;
        o_cmd.status = ST_BAD_METHOD;
        o_cmd.tbl_wr = acc && i_mode;
        mid          = r_phase;
        case (r_phase)
            PH_IDLE: begin
                if (acc_byte) begin
                    if (i_sts.b_nul) begin
                        o_cmd.emit = 1'b1;
                    end else if (!i_sts.b_crlf) begin
                        o_cmd.ld_first = 1'b1;
                        mid            = PH_SECOND;
                    end
                end
            end
            PH_SECOND: begin
                if (acc_byte) begin
                    if (i_sts.method_ok) begin
                        mid = PH_SEEK;
                    end else begin
                        o_cmd.emit = 1'b1;
                    end
                end
            end
            PH_SEEK: begin
                if (acc_byte) begin
                    if (i_sts.b_nul || i_sts.b_crlf) begin
                        o_cmd.emit   = 1'b1;
                        o_cmd.status = ST_NO_URI;
                    end else if (i_sts.b_slash) begin
                        o_cmd.hash_en = 1'b1;
                        mid           = PH_URI;
                    end
                end
            end
            PH_URI: begin
                if (acc_byte) begin
                    if (i_sts.b_nul || i_sts.b_crlf) begin
                        o_cmd.emit   = 1'b1;
                        o_cmd.status = ST_NO_URI;
                    end else if (i_sts.b_space) begin
                        if (i_sts.too_long) begin
                            o_cmd.emit   = 1'b1;
                            o_cmd.status = ST_TOO_LONG;
                        end else if (i_sts.is_post) begin
                            o_cmd.emit   = 1'b1;
                            o_cmd.status = ST_POST;
                        end else begin
                            o_cmd.search_start = 1'b1;
                            mid                = PH_SEARCH;
                        end
                    end else begin
                        o_cmd.hash_en = 1'b1;
                    end
                end
            end
            PH_SEARCH: begin
                if (i_sts.hit || i_sts.exhausted) begin
                    if (!i_sts.out_busy) begin
                        o_cmd.emit   = 1'b1;
                        o_cmd.status = i_sts.hit ? ST_FOUND : ST_NOT_FOUND;
                        o_cmd.clear  = r_last;
                    end
                end else begin
                    o_cmd.search_step = 1'b1;
                end
            end
            default: begin
            end
        endcase
        // last byte closes an open request
        if (acc_byte && i_last && !o_cmd.emit) begin
            if (mid == PH_IDLE || mid == PH_SECOND) begin
                o_cmd.emit   = 1'b1;
                o_cmd.status = ST_BAD_METHOD;
            end else if (mid == PH_SEEK || mid == PH_URI) begin
                o_cmd.emit   = 1'b1;
                o_cmd.status = ST_NO_URI;
            end
        end
        if (acc_byte && i_last && !o_cmd.search_start) begin
            o_cmd.clear = 1'b1;
        end
    end

    // next state
    always_comb begin
        n_phase = r_phase;
        n_last  = r_last;
        case (r_phase)
            PH_IDLE: begin
                if (o_cmd.ld_first) begin
                    n_phase = PH_SECOND;
                end
            end
            PH_SECOND: begin
                if (acc_byte && i_sts.method_ok) begin
                    n_phase = PH_SEEK;
                end
            end
            PH_SEEK: begin
                if (acc_byte && i_sts.b_slash && !i_sts.b_nul && !i_sts.b_crlf) begin
                    n_phase = PH_URI;
                end
            end
            PH_URI: begin
                if (o_cmd.search_start) begin
                    n_phase = PH_SEARCH;
                    n_last  = i_last;
                end
            end
            default: begin
            end
        endcase
        if (o_cmd.clear) begin
            n_phase = PH_IDLE;
        end else if (o_cmd.emit) begin
            n_phase = PH_DONE;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_IDLE;
            r_last  <= 1'b0;
        end else begin
            r_phase <= n_phase;
            r_last  <= n_last;
        end
    end

`ifndef SYNTHESIS
    a_emit_room: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.emit |-> !i_sts.out_busy)
        else $error("result issued while output register is held");

    // a hashed byte can only meet a result when data ends on it
    a_hash_or_emit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_cmd.hash_en && o_cmd.emit) |-> (o_cmd.status == ST_NO_URI) && o_cmd.clear)
        else $error("hash update alongside a result that carries the hash");

    a_clear_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.clear |=> r_phase == PH_IDLE)
        else $error("request end did not return to idle");

    a_search_enter: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.search_start |=> (r_phase == PH_SEARCH) && $stable(i_sts.too_long))
        else $error("route search not entered");
`endif

endmodule

// ===== rtl/http_request_line_route_matcher.sv =====
// Top level of the request line route matcher: ports and wiring of
// hrlm_ctrl and hrlm_dp. Uses hrlm_pkg.
//
//  channel      handshake                      carries
//  s_axis       s_axis_tvalid / s_axis_tready  request byte or route table write
//  m_axis       m_axis_tvalid / m_axis_tready  one status word per request
//  cfg          i_cfg_wr_en                    route_count
//
// Request bytes and table writes are each taken on an s_axis handshake.
// A GET URI ending in a space starts a serial table search, one slot per
// cycle through the table's registered read port, over at most
// min(route_count, MAX_ROUTES) slots, input stalled meanwhile.
// Reset (i_rst_n low, synchronous) clears the parse and route_count; table
// contents are undefined until written.
// The result sits in an output register. While m_axis_tready low holds it,
// input stalls, except for the bytes that follow the request's result.
module http_request_line_route_matcher import hrlm_pkg::*; #(
    parameter int MAX_ROUTES = MAX_ROUTES_DEF,
    parameter int MAX_URI    = MAX_URI_DEF
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    // configuration: route_count
    input  logic              i_cfg_wr_en,
    input  logic [CFG_W-1:0]  i_cfg_wr_data,
    // request input
    input  logic              s_axis_tvalid,
    output logic              s_axis_tready,
    // [7:0] data_byte, [11:8] entry_index, [43:12] entry_hash, rest zero
    input  logic [IN_DW-1:0]  s_axis_tdata,
    input  logic              s_axis_tlast,   // end_of_data
    input  logic              s_axis_tuser,   // mode: 0 byte, 1 table write
    // result output
    output logic              m_axis_tvalid,
    input  logic              m_axis_tready,
    // [2:0] status, [3] method, [10:4] path length, [42:11] path hash,
    // [46:43] route_index, [47] zero
    output logic [OUT_DW-1:0] m_axis_tdata
);

    t_cmd cmd;
    t_sts sts;

    // FSM: phase tracking, byte commands, search sequencing
    hrlm_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (s_axis_tvalid),
        .i_mode  (s_axis_tuser),
        .i_last  (s_axis_tlast),
        .o_ready (s_axis_tready),
        .i_sts   (sts),
        .o_cmd   (cmd)
    );

    // hash, counters, route table and result register
    hrlm_dp #(
        .MAX_ROUTES (MAX_ROUTES),
        .MAX_URI    (MAX_URI)
    ) u_dp (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cmd         (cmd),
        .o_sts         (sts),
        .i_cfg_wr_en   (i_cfg_wr_en),
        .i_cfg_wr_data (i_cfg_wr_data),
        .i_byte        (s_axis_tdata[7:0]),
        .i_entry_index (s_axis_tdata[11:8]),
        .i_entry_hash  (s_axis_tdata[43:12]),
        .i_out_ready   (m_axis_tready),
        .o_out_valid   (m_axis_tvalid),
        .o_out_data    (m_axis_tdata)
    );

endmodule
